>>> sv/pnmhp_pkg.sv
// Package: shared types, codes and byte classes for the PNM header parser.
`timescale 1ns / 1ps
`default_nettype none

package pnmhp_pkg;

   typedef enum logic [9:0] {
      PH_IDLE   = 10'b00_0000_0001,
      PH_MAGIC  = 10'b00_0000_0010,
      PH_TYPE   = 10'b00_0000_0100,
      PH_SKIP_W = 10'b00_0000_1000,
      PH_NUM_W  = 10'b00_0001_0000,
      PH_SKIP_H = 10'b00_0010_0000,
      PH_NUM_H  = 10'b00_0100_0000,
      PH_SKIP_M = 10'b00_1000_0000,
      PH_NUM_M  = 10'b01_0000_0000,
      PH_EOL    = 10'b10_0000_0000
   } phase_type;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_BAD_MAGIC    = 3'd1;
   localparam logic [2:0] ST_BAD_TYPE     = 3'd2;
   localparam logic [2:0] ST_TYPE_MISMATCH = 3'd3;
   localparam logic [2:0] ST_NO_NUMBER    = 3'd4;
   localparam logic [2:0] ST_OVERFLOW     = 3'd5;
   localparam logic [2:0] ST_TRUNCATED    = 3'd6;

   localparam logic [2:0] ANY_TYPE = 3'd7;

   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SIX   = 8'h36;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      phase_type   phase;
      logic        in_comment;
      logic [2:0]  file_type;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] max_value;
      logic [15:0] header_length;
   } parse_state_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

endpackage

`default_nettype wire

>>> sv/pnmhp_step.sv
// Combinational next-state logic: advances the header parse by one byte.
`timescale 1ns / 1ps
`default_nettype none

module pnmhp_step #(
   parameter int VALUE_BITS = 16
) (
   input  pnmhp_pkg::parse_state_type state_i,
   input  logic [VALUE_BITS+3:0]      acc_i,
   input  logic [7:0]                 data_byte,
   input  logic                       first_byte,
   input  logic                       last_byte,
   input  logic [2:0]                 required_type,
   output pnmhp_pkg::parse_state_type state_o,
   output logic [VALUE_BITS+3:0]      acc_o,
   output logic                       emit_o,
   output logic [2:0]                 status_o
);
   import pnmhp_pkg::*;

   localparam int AccW = VALUE_BITS + 4;
   localparam logic [AccW-1:0] ValueMax = {4'b0000, {VALUE_BITS{1'b1}}};

   parse_state_type cur;
   parse_state_type st;
   logic [AccW-1:0] acc;
   logic [AccW-1:0] dval;
   logic [AccW-1:0] acc_x10;
   logic            emit;
   logic [2:0]      status;
   logic            consume;
   logic            do_skip;
   logic            do_eol;
   logic            digit;
   logic [2:0]      type_val;

   assign digit    = is_digit(data_byte);
   assign dval     = AccW'(data_byte[3:0]);
   assign type_val = data_byte[2:0];

   always_comb begin
      cur = state_i;
      acc = acc_i;
      if (first_byte) begin
         cur        = '0;
         cur.phase  = PH_MAGIC;
         acc        = '0;
      end
      st      = cur;
      emit    = 1'b0;
      status  = ST_OK;
      consume = 1'b0;
      do_skip = 1'b0;
      do_eol  = 1'b0;
      acc_x10 = (acc << 3) + (acc << 1) + dval;

      unique case (cur.phase)
         PH_IDLE: begin
         end
         PH_MAGIC: begin
            if (data_byte != CH_P) begin
               emit   = 1'b1;
               status = ST_BAD_MAGIC;
            end else begin
               consume  = 1'b1;
               st.phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            if ((data_byte < CH_ZERO) || (data_byte > CH_SIX)) begin
               emit   = 1'b1;
               status = ST_BAD_TYPE;
            end else begin
               st.file_type = type_val;
               if ((required_type != ANY_TYPE) && (required_type != type_val)) begin
                  emit   = 1'b1;
                  status = ST_TYPE_MISMATCH;
               end else begin
                  consume  = 1'b1;
                  st.phase = PH_SKIP_W;
               end
            end
         end
         PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
            do_skip = 1'b1;
         end
         PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
            if (digit) begin
               if (acc_x10 > ValueMax) begin
                  acc    = ValueMax;
                  emit   = 1'b1;
                  status = ST_OVERFLOW;
                  if (cur.phase == PH_NUM_W) begin
                     st.width = 16'(ValueMax);
                  end else if (cur.phase == PH_NUM_H) begin
                     st.height = 16'(ValueMax);
                  end else begin
                     st.max_value = 16'(ValueMax);
                  end
               end else begin
                  acc     = acc_x10;
                  consume = 1'b1;
               end
            end else if (cur.phase == PH_NUM_W) begin
               // number ended: this byte is then handled by the following phase
               st.width = 16'(acc);
               st.phase = PH_SKIP_H;
               do_skip  = 1'b1;
            end else if (cur.phase == PH_NUM_H) begin
               st.height = 16'(acc);
               st.phase  = PH_SKIP_M;
               do_skip   = 1'b1;
            end else begin
               st.max_value = 16'(acc);
               st.phase     = PH_EOL;
               do_eol       = 1'b1;
            end
         end
         PH_EOL: begin
            do_eol = 1'b1;
         end
         default: begin
         end
      endcase

      if (do_skip) begin
         if (st.in_comment) begin
            if (data_byte == CH_LF) begin
               st.in_comment = 1'b0;
            end
            consume = 1'b1;
         end else if (data_byte == CH_HASH) begin
            st.in_comment = 1'b1;
            consume       = 1'b1;
         end else if (is_space(data_byte)) begin
            consume = 1'b1;
         end else if (digit) begin
            acc     = dval;
            consume = 1'b1;
            if (st.phase == PH_SKIP_W) begin
               st.phase = PH_NUM_W;
            end else if (st.phase == PH_SKIP_H) begin
               st.phase = PH_NUM_H;
            end else begin
               st.phase = PH_NUM_M;
            end
         end else begin
            emit   = 1'b1;
            status = ST_NO_NUMBER;
         end
      end

      if (do_eol) begin
         if ((data_byte == CH_LF) || (data_byte == CH_CR)) begin
            consume = 1'b1;
            emit    = 1'b1;
            status  = ST_OK;
         end else if (!is_space(data_byte)) begin
            emit   = 1'b1;
            status = ST_OK;
         end else begin
            consume = 1'b1;
         end
      end

      if (consume && (st.header_length != COUNT_MAX)) begin
         st.header_length = st.header_length + 16'd1;
      end

      // end of file: complete inside maxval digits or trailing whitespace
      if ((cur.phase != PH_IDLE) && !emit && last_byte) begin
         emit = 1'b1;
         if (st.phase == PH_NUM_M) begin
            st.max_value = 16'(acc);
            status       = ST_OK;
         end else if (st.phase == PH_EOL) begin
            status = ST_OK;
         end else begin
            status = ST_TRUNCATED;
         end
      end

      if (emit) begin
         st.phase      = PH_IDLE;
         st.in_comment = 1'b0;
      end
   end

   assign state_o  = st;
   assign acc_o    = acc;
   assign emit_o   = emit;
   assign status_o = status;

endmodule

`default_nettype wire

>>> sv/pnm_header_parser.sv
// Top level: PNM header parser with input register, parse state and result register.
// Path: an accepted byte waits in the input register, is parsed by the combinational step
// once the result register is free or being read, and a closing byte's result is caught there.
// Throughput: one byte per cycle; the parse state advances once per byte through one
// combinational step, and the input register stalls only while a result waits.
// Reset (synchronous, active high): parser idle until a first byte, result and input
// registers empty, required type set to accept any type.
`timescale 1ns / 1ps
`default_nettype none

module pnm_header_parser #(
   parameter int VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_file_type,
   output logic [15:0] rsp_width,
   output logic [15:0] rsp_height,
   output logic [15:0] rsp_max_value,
   output logic [15:0] rsp_header_length,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data
);
   import pnmhp_pkg::*;

   localparam int AccW = VALUE_BITS + 4;

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_first_ff;
   logic                  in_last_ff;
   logic [2:0]            req_type_ff;
   parse_state_type       state_ff;
   parse_state_type       state_in;
   logic [AccW-1:0]       acc_ff;
   logic [AccW-1:0]       acc_in;
   logic                  emit;
   logic [2:0]            status;
   logic                  proc_go;
   logic                  rsp_valid_ff;
   logic [2:0]            rsp_status_ff;
   logic [2:0]            rsp_file_type_ff;
   logic [15:0]           rsp_width_ff;
   logic [15:0]           rsp_height_ff;
   logic [15:0]           rsp_max_value_ff;
   logic [15:0]           rsp_header_length_ff;

   assign proc_go   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc_go;

   pnmhp_step #(
      .VALUE_BITS(VALUE_BITS)
   ) u_step (
      .state_i      (state_ff),
      .acc_i        (acc_ff),
      .data_byte    (in_byte_ff),
      .first_byte   (in_first_ff),
      .last_byte    (in_last_ff),
      .required_type(req_type_ff),
      .state_o      (state_in),
      .acc_o        (acc_in),
      .emit_o       (emit),
      .status_o     (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         req_type_ff    <= ANY_TYPE;
         state_ff       <= '{phase: PH_IDLE, default: '0};
         acc_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            req_type_ff <= csr_write_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (proc_go) begin
            state_ff <= state_in;
            acc_ff   <= acc_in;
         end
         if (proc_go && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first_byte;
         in_last_ff  <= req_last_byte;
      end
      if (proc_go && emit) begin
         rsp_status_ff        <= status;
         rsp_file_type_ff     <= state_in.file_type;
         rsp_width_ff         <= state_in.width;
         rsp_height_ff        <= state_in.height;
         rsp_max_value_ff     <= state_in.max_value;
         rsp_header_length_ff <= state_in.header_length;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_file_type     = rsp_file_type_ff;
   assign rsp_width         = rsp_width_ff;
   assign rsp_height        = rsp_height_ff;
   assign rsp_max_value     = rsp_max_value_ff;
   assign rsp_header_length = rsp_header_length_ff;

endmodule

`default_nettype wire

>>> sv/pnmhp_checker.sv
// Checker: port-level assertions on the PNM header parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pnmhp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [2:0]  rsp_file_type,
   input wire logic [15:0] rsp_width,
   input wire logic [15:0] rsp_height,
   input wire logic [15:0] rsp_max_value,
   input wire logic [15:0] rsp_header_length
);
   import pnmhp_pkg::*;

   // a stalled result transaction keeps its payload (all fields but the file type)
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_width) && $stable(rsp_height) && $stable(rsp_max_value)
         && $stable(rsp_header_length))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_TRUNCATED) && (rsp_file_type <= 3'd6))
      else $error("status or file type out of range");

   // bad magic is found on the first byte, before anything is counted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BAD_MAGIC) |->
         (rsp_header_length == 16'd0) && (rsp_width == 16'd0))
      else $error("bad magic with consumed bytes");

   // a complete header has at least magic, type and one digit per number
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |-> (rsp_header_length >= 16'd5))
      else $error("ok header too short");

endmodule

bind pnm_header_parser pnmhp_checker u_checker (.*);

`default_nettype wire

>>> dv/pnm_header_parser_tb.sv
// Testbench for pnm_header_parser: directed and random PNM headers checked against a predictor.
`timescale 1ns / 1ps

module pnm_header_parser_tb;
   import pnmhp_pkg::*;

   localparam int VALUE_BITS = 16;
   localparam int unsigned VALUE_MAX = 32'((64'd1 << VALUE_BITS) - 64'd1);
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  file_type;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] max_value;
      logic [15:0] header_length;
   } header_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_first_byte = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_file_type;
   logic [15:0] rsp_width;
   logic [15:0] rsp_height;
   logic [15:0] rsp_max_value;
   logic [15:0] rsp_header_length;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_write_data = 3'd0;

   pnm_header_parser #(
      .VALUE_BITS(VALUE_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_first_byte(req_first_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_file_type(rsp_file_type),
      .rsp_width(rsp_width),
      .rsp_height(rsp_height),
      .rsp_max_value(rsp_max_value),
      .rsp_header_length(rsp_header_length),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   header_result_type expected_headers[$];
   logic [7:0]        file_bytes[$];
   int                error_count = 0;
   int                cycle_count = 0;
   int                bytes_sent = 0;
   int                headers_predicted = 0;
   bit                gaps_on = 1'b1;
   int                stall_left = 0;

   // parser state mirror
   logic [2:0]  required_type;
   phase_type   hdr_phase;
   bit          hdr_in_comment;
   int unsigned hdr_acc;
   logic [15:0] hdr_width;
   logic [15:0] hdr_height;
   logic [15:0] hdr_maxval;
   logic [2:0]  hdr_type;
   logic [15:0] hdr_length;

   task automatic report(input string msg);
      $display("ERROR: %s (cycle %0d)", msg, cycle_count);
      error_count++;
   endtask

   function automatic bit is_blank(input logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function automatic bit is_decimal(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic void clear_header();
      hdr_in_comment = 1'b0;
      hdr_acc = 0;
      hdr_width = '0;
      hdr_height = '0;
      hdr_maxval = '0;
      hdr_type = '0;
      hdr_length = '0;
   endfunction

   function automatic void count_byte();
      if (hdr_length != COUNT_MAX)
         hdr_length = hdr_length + 16'd1;
   endfunction

   function automatic void store_value(input int unsigned v);
      case (hdr_phase)
         PH_NUM_W: hdr_width = v[15:0];
         PH_NUM_H: hdr_height = v[15:0];
         default:  hdr_maxval = v[15:0];
      endcase
   endfunction

   function automatic phase_type next_phase(input phase_type p);
      case (p)
         PH_SKIP_W: return PH_NUM_W;
         PH_NUM_W:  return PH_SKIP_H;
         PH_SKIP_H: return PH_NUM_H;
         PH_NUM_H:  return PH_SKIP_M;
         PH_SKIP_M: return PH_NUM_M;
         default:   return PH_EOL;
      endcase
   endfunction

   function automatic void close_header(input logic [2:0] st, output header_result_type r);
      r.status = st;
      r.file_type = hdr_type;
      r.width = hdr_width;
      r.height = hdr_height;
      r.max_value = hdr_maxval;
      r.header_length = hdr_length;
      hdr_phase = PH_IDLE;
      hdr_in_comment = 1'b0;
   endfunction

   // Advances the mirror by one byte; returns 1 when the byte closes a header.
   function automatic bit predict_header_byte(input logic [7:0] b, input bit first,
                                              input bit last, output header_result_type r);
      bit again;
      r = '0;
      if (first) begin
         clear_header();
         hdr_phase = PH_MAGIC;
      end
      if (hdr_phase == PH_IDLE)
         return 1'b0;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (hdr_phase)
            PH_MAGIC: begin
               if (b != CH_P) begin
                  close_header(ST_BAD_MAGIC, r);
                  return 1'b1;
               end
               count_byte();
               hdr_phase = PH_TYPE;
            end
            PH_TYPE: begin
               if (b < CH_ZERO || b > CH_SIX) begin
                  close_header(ST_BAD_TYPE, r);
                  return 1'b1;
               end
               hdr_type = 3'(b - CH_ZERO);
               if (required_type != ANY_TYPE && required_type != hdr_type) begin
                  close_header(ST_TYPE_MISMATCH, r);
                  return 1'b1;
               end
               count_byte();
               hdr_phase = PH_SKIP_W;
            end
            PH_EOL: begin
               if (b == CH_LF || b == CH_CR) begin
                  count_byte();
                  close_header(ST_OK, r);
                  return 1'b1;
               end
               // a non-space byte ends the header and is left uncounted
               if (!is_blank(b)) begin
                  close_header(ST_OK, r);
                  return 1'b1;
               end
               count_byte();
            end
            PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
               if (hdr_in_comment) begin
                  if (b == CH_LF)
                     hdr_in_comment = 1'b0;
                  count_byte();
               end else if (b == CH_HASH) begin
                  hdr_in_comment = 1'b1;
                  count_byte();
               end else if (is_blank(b)) begin
                  count_byte();
               end else if (is_decimal(b)) begin
                  hdr_acc = b - CH_ZERO;
                  count_byte();
                  hdr_phase = next_phase(hdr_phase);
               end else begin
                  close_header(ST_NO_NUMBER, r);
                  return 1'b1;
               end
            end
            default: begin
               if (is_decimal(b)) begin
                  hdr_acc = hdr_acc * 10 + (b - CH_ZERO);
                  if (hdr_acc > VALUE_MAX) begin
                     store_value(VALUE_MAX);
                     close_header(ST_OVERFLOW, r);
                     return 1'b1;
                  end
                  count_byte();
               end else begin
                  // number done: same byte goes through the next phase
                  store_value(hdr_acc);
                  hdr_phase = next_phase(hdr_phase);
                  again = 1'b1;
               end
            end
         endcase
      end
      if (last) begin
         if (hdr_phase == PH_NUM_M) begin
            hdr_maxval = hdr_acc[15:0];
            close_header(ST_OK, r);
         end else if (hdr_phase == PH_EOL) begin
            close_header(ST_OK, r);
         end else begin
            close_header(ST_TRUNCATED, r);
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
      header_result_type r;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_first_byte <= first;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      if (predict_header_byte(b, first, last, r)) begin
         expected_headers.push_back(r);
         headers_predicted++;
      end
   endtask

   task automatic send_text(input string s, input bit is_new, input bit mark_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], is_new && i == 0, mark_last && i == s.len() - 1);
   endtask

   task automatic send_file(input bit mark_last);
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == 0, mark_last && i == file_bytes.size() - 1);
   endtask

   // all results in and the last transaction parsed
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_headers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_required_type(input logic [2:0] v);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      required_type = v;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= (stall_left == 0);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic compare_field(input string name, input int unsigned got,
                                input int unsigned want);
      if (got != want)
         report($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      header_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_headers.size() == 0) begin
            report($sformatf("unexpected result, status %0d", rsp_status));
         end else begin
            want = expected_headers.pop_front();
            compare_field("status", rsp_status, want.status);
            compare_field("file_type", rsp_file_type, want.file_type);
            compare_field("width", rsp_width, want.width);
            compare_field("height", rsp_height, want.height);
            compare_field("max_value", rsp_max_value, want.max_value);
            compare_field("header_length", rsp_header_length, want.header_length);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results pending", expected_headers.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic test_good_headers();
      send_text("P0 0 0 0\n", 1, 1);
      send_text("P6\n# max sizes\n65535 65535\n65535\015", 1, 1);
      send_text("P1\011 12\013\01434 # note\015 more\n 255 \n", 1, 1);
      send_text("P5 3 4 255 X", 1, 1);
      send_text("P2 7 8 9\015\n", 1, 1);
      send_text("P3#a\n007 0010\n#b\n#c\n00099\011\n", 1, 1);
      send_text("P4 1 2 3    \014\n", 1, 1);
   endtask

   task automatic test_header_errors();
      send_text("Q6 1 1 1\n", 1, 1);
      send_text("P7 1 1 1\n", 1, 1);
      send_text("P/ 1 1 1\n", 1, 1);
      send_text("P3 +1 2 3\n", 1, 1);
      send_text("P3 1 -2 3\n", 1, 1);
      send_text("P5 1 2 x\n", 1, 1);
      send_text("P4 65536 1 1\n", 1, 1);
      send_text("P4 1 99999 1\n", 1, 1);
      send_text("P4 1 1 700000\n", 1, 1);
      // no first byte: ignored while idle
      send_text("P6 1 1 1\n", 0, 1);
      // first byte restarts a file in progress
      send_text("P6 12 ", 1, 0);
      send_text("P3 1 2 3\n", 1, 1);
   endtask

   task automatic test_file_end();
      send_text("P6 1 2 255", 1, 1);
      send_text("P6 1 2 255 \011", 1, 1);
      send_text("P6 1 2", 1, 1);
      send_text("P", 1, 1);
      send_text("P6 1 2 ", 1, 1);
      send_text("P6 # comment", 1, 1);
      send_text("P6 1 2 3x", 1, 1);
      send_text("P6 1 2 +", 1, 1);
      send_text("P6 1 2 99999", 1, 1);
   endtask

   task automatic test_type_filter();
      set_required_type(3'd0);
      send_text("P0 1 1 1\n", 1, 1);
      send_text("P6 1 1 1\n", 1, 1);
      set_required_type(3'd6);
      send_text("P6 2 2 2\n", 1, 1);
      send_text("P0 2 2 2\n", 1, 1);
      send_text("P9 2 2 2\n", 1, 1);
      set_required_type(ANY_TYPE);
   endtask

   function automatic void add_gap(input bit allow_none);
      int n;
      int len;
      n = (allow_none && $urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
      repeat (n) begin
         case ($urandom_range(0, 7))
            0, 1, 2, 3: file_bytes.push_back(CH_SPACE);
            4: file_bytes.push_back(CH_LF);
            5: file_bytes.push_back(CH_TAB);
            6: file_bytes.push_back(8'($urandom_range(CH_TAB + 2, CH_CR)));
            default: begin
               file_bytes.push_back(CH_HASH);
               len = $urandom_range(0, 6);
               repeat (len) file_bytes.push_back(8'($urandom_range(0, 255)) | 8'h80);
               if ($urandom_range(0, 1) == 0)
                  file_bytes.push_back(CH_CR);
               file_bytes.push_back(CH_LF);
            end
         endcase
      end
   endfunction

   function automatic void add_number();
      int unsigned v;
      string s;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = VALUE_MAX;
         2: v = $urandom_range(VALUE_MAX + 1, 999999);
         3: v = $urandom_range(0, 99);
         default: v = $urandom_range(1, 999);
      endcase
      s = $sformatf("%0d", v);
      if ($urandom_range(0, 9) == 0)
         s = {"00", s};
      for (int i = 0; i < s.len(); i++)
         file_bytes.push_back(s[i]);
   endfunction

   function automatic void build_random_file();
      int n;
      file_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 0)
            file_bytes[0] = CH_P;
         return;
      end
      file_bytes.push_back($urandom_range(0, 19) == 0 ? 8'($urandom_range(0, 255)) : CH_P);
      if ($urandom_range(0, 14) == 0)
         file_bytes.push_back(8'($urandom_range(0, 255)));
      else if (required_type != ANY_TYPE && $urandom_range(0, 3) != 0)
         file_bytes.push_back(CH_ZERO + required_type);
      else
         file_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 6)));
      for (int k = 0; k < 3; k++) begin
         add_gap(1'b1);
         add_number();
      end
      case ($urandom_range(0, 4))
         0: file_bytes.push_back(CH_LF);
         1: file_bytes.push_back(CH_CR);
         2: begin
            file_bytes.push_back(CH_SPACE);
            file_bytes.push_back(CH_LF);
         end
         3: begin
            file_bytes.push_back(CH_CR);
            file_bytes.push_back(CH_LF);
         end
         default: file_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
      n = $urandom_range(0, 3);
      repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 5) == 0)
         file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > n) void'(file_bytes.pop_back());
      end
   endfunction

   task automatic run_random_files(input logic [2:0] rt, input int min_bytes,
                                   input int min_headers);
      int byte_goal;
      int header_goal;
      set_required_type(rt);
      byte_goal = bytes_sent + min_bytes;
      header_goal = headers_predicted + min_headers;
      while (bytes_sent < byte_goal || headers_predicted < header_goal) begin
         build_random_file();
         send_file($urandom_range(0, 7) != 0);
      end
   endtask

   task automatic test_random();
      run_random_files(ANY_TYPE, 80, 6);
      run_random_files(3'd0, 40, 3);
      run_random_files(3'd6, 40, 3);
      run_random_files(3'($urandom_range(1, 5)), 40, 3);
      set_required_type(ANY_TYPE);
      gaps_on = 1'b0;
      run_random_files(ANY_TYPE, 40, 3);
   endtask

   initial begin
      required_type = ANY_TYPE;
      hdr_phase = PH_IDLE;
      clear_header();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_good_headers();
      test_header_errors();
      test_file_end();
      test_type_filter();
      test_random();

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
